@@ rtl/core/bmg_pkg.sv @@
package bmg_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned LOG_FRAC_BITS = 26;
   localparam int unsigned CORDIC_ITERS  = 28;
   localparam int unsigned ISQRT_STEPS   = 30;
   localparam int unsigned ISQRT_W       = 2 * ISQRT_STEPS;
   localparam int unsigned ROOT_W        = ISQRT_STEPS;
   localparam int unsigned CORDIC_W      = 34;
   localparam int unsigned ANGLE_W       = 33;

   localparam logic [WORD_W-1:0] ZERO_SUBST = 32'd4295;
   localparam logic [WORD_W-1:0] LN2_Q32    = 32'd2977044472;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // arctangent of 2^-i, in Q0.32 turns
   function automatic logic [WORD_W-1:0] atan_turn(input logic [4:0] idx);
      logic [WORD_W-1:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/bmg_cordic.sv @@
module bmg_cordic (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [bmg_pkg::WORD_W-1:0]            angle,
   output logic signed [bmg_pkg::CORDIC_W-1:0]   cosine
);

   localparam int unsigned N  = bmg_pkg::CORDIC_ITERS;
   localparam int unsigned XW = bmg_pkg::CORDIC_W;
   localparam int unsigned ZW = bmg_pkg::ANGLE_W;

   logic signed [XW-1:0] x_ff [0:N];
   logic signed [XW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic [1:0]           q_ff [0:N];

   logic [bmg_pkg::WORD_W-1:0] turn;

   // rotate so the residual sits within an eighth of a turn of a quadrant axis
   always_comb begin
      turn = angle + 32'h20000000;
   end

   always_comb begin
      x_ff[0] = bmg_pkg::CORDIC_GAIN_Q30;
      y_ff[0] = '0;
      z_ff[0] = $signed({3'b000, turn[29:0]}) - $signed(33'h020000000);
      q_ff[0] = turn[31:30];
   end

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_iter
         logic signed [XW-1:0] x_in, y_in;
         logic signed [ZW-1:0] z_in;
         logic signed [XW-1:0] xs, ys;
         logic signed [ZW-1:0] at;
         always_comb begin
            xs = x_ff[i] >>> i;
            ys = y_ff[i] >>> i;
            at = $signed({1'b0, bmg_pkg::atan_turn(5'(i))});
            if (!z_ff[i][ZW-1]) begin
               x_in = x_ff[i] - ys;
               y_in = y_ff[i] + xs;
               z_in = z_ff[i] - at;
            end else begin
               x_in = x_ff[i] + ys;
               y_in = y_ff[i] - xs;
               z_in = z_ff[i] + at;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               x_ff[i+1] <= x_in;
               y_ff[i+1] <= y_in;
               z_ff[i+1] <= z_in;
               q_ff[i+1] <= q_ff[i];
            end
         end
      end
   endgenerate

   always_comb begin
      case (q_ff[N])
         2'd0:    cosine = x_ff[N];
         2'd1:    cosine = -y_ff[N];
         2'd2:    cosine = -x_ff[N];
         default: cosine = y_ff[N];
      endcase
   end

endmodule

@@ rtl/core/bmg_isqrt.sv @@
module bmg_isqrt (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [bmg_pkg::ISQRT_W-1:0]        radicand,
   output logic [bmg_pkg::ROOT_W-1:0]         root
);

   localparam int unsigned N = bmg_pkg::ISQRT_STEPS;
   localparam int unsigned W = bmg_pkg::ISQRT_W;

   logic [W-1:0] v_ff   [0:N];
   logic [W-1:0] res_ff [0:N];

   always_comb begin
      v_ff[0]   = radicand;
      res_ff[0] = '0;
   end

   genvar j;
   generate
      for (j = 0; j < N; j++) begin : g_step
         localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * (N - 1 - j));
         logic [W-1:0] trial;
         logic [W-1:0] v_in, res_in;
         always_comb begin
            trial = res_ff[j] + BIT;
            if (v_ff[j] >= trial) begin
               v_in   = v_ff[j] - trial;
               res_in = (res_ff[j] >> 1) + BIT;
            end else begin
               v_in   = v_ff[j];
               res_in = res_ff[j] >> 1;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               v_ff[j+1]   <= v_in;
               res_ff[j+1] <= res_in;
            end
         end
      end
   endgenerate

   assign root = res_ff[N][bmg_pkg::ROOT_W-1:0];

endmodule

@@ rtl/core/box_muller_gaussian.sv @@
// Box-Muller Gaussian source, cosine branch.
// Input words carry two Q0.32 uniforms on req_uniform_radius and
// req_uniform_angle; each gives one Q5.26 sample on rsp_gaussian_sample.
// Both channels use valid/ready; a word moves when valid and ready are high.
// A zero radius is treated as 4295 (about 1e-6).
// From acceptance to rsp_valid a word passes the pipeline registers:
// one normalize stage, 26 log2 squaring stages, one ln2 multiply stage,
// 30 square-root digit stages (the cosine CORDIC runs 28 stages beside
// them) and one final multiply stage that is the output register.
// Throughput: one word per cycle while the receiver takes results.
// When rsp_ready is low with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset clears every valid bit; the data registers are not reset.
module box_muller_gaussian (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [bmg_pkg::WORD_W-1:0]              req_uniform_radius,
   input  logic [bmg_pkg::WORD_W-1:0]              req_uniform_angle,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bmg_pkg::WORD_W-1:0]       rsp_gaussian_sample
);

   localparam int unsigned W      = bmg_pkg::WORD_W;
   localparam int unsigned NLOG   = bmg_pkg::LOG_FRAC_BITS;
   localparam int unsigned NSQ    = bmg_pkg::ISQRT_STEPS;
   localparam int unsigned ALIGN  = bmg_pkg::ISQRT_STEPS - bmg_pkg::CORDIC_ITERS;
   localparam int unsigned DEPTH  = NLOG + NSQ + 3;
   localparam int unsigned XW     = bmg_pkg::CORDIC_W;

   logic advance;
   logic valid_ff [0:DEPTH-1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // normalize stage
   logic [W-1:0] u1;
   logic [4:0]   lead;
   logic [W-1:0] m_in;

   always_comb begin
      u1 = (req_uniform_radius == '0) ? bmg_pkg::ZERO_SUBST : req_uniform_radius;
      lead = '0;
      for (int b = 0; b < W; b++) begin
         if (u1[b]) lead = 5'(b);
      end
      m_in = u1 << (5'd31 - lead);
   end

   logic [W-1:0]      m_ff   [0:NLOG];
   logic [NLOG-1:0]   f_ff   [0:NLOG];
   logic [4:0]        p_ff   [0:NLOG];
   logic [W-1:0]      ang_ff [0:NLOG+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff[0]   <= m_in;
         f_ff[0]   <= '0;
         p_ff[0]   <= lead;
         ang_ff[0] <= req_uniform_angle;
      end
   end

   // one fraction bit of log2 per squaring stage
   genvar k;
   generate
      for (k = 0; k < NLOG; k++) begin : g_log
         logic [2*W-1:0] sq;
         logic [W:0]     t;
         logic [W-1:0]   m_next;
         logic [NLOG-1:0] f_next;
         always_comb begin
            sq = m_ff[k] * m_ff[k];
            t  = sq[2*W-1:W-1];
            if (t[W]) begin
               m_next = t[W:1];
               f_next = f_ff[k] | (NLOG'(1) << (NLOG - 1 - k));
            end else begin
               m_next = t[W-1:0];
               f_next = f_ff[k];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               m_ff[k+1]   <= m_next;
               f_ff[k+1]   <= f_next;
               p_ff[k+1]   <= p_ff[k];
               ang_ff[k+1] <= ang_ff[k];
            end
         end
      end
   endgenerate

   // -2 ln u = -log2 u * ln2 * 2, kept in Q.52
   logic [W-1:0]                 lq;
   logic [2*W-1:0]               prod_ln;
   logic [bmg_pkg::ISQRT_W-1:0]  r_ff;

   always_comb begin
      lq      = ({26'd0, 6'd32 - {1'b0, p_ff[NLOG]}} << NLOG) - {6'd0, f_ff[NLOG]};
      prod_ln = lq * bmg_pkg::LN2_Q32;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff           <= bmg_pkg::ISQRT_W'(prod_ln >> 5);
         ang_ff[NLOG+1] <= ang_ff[NLOG];
      end
   end

   logic [bmg_pkg::ROOT_W-1:0] root;
   logic signed [XW-1:0]       cosine;

   bmg_isqrt u_isqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (r_ff),
      .root     (root)
   );

   bmg_cordic u_cordic (
      .clock   (clock),
      .advance (advance),
      .angle   (ang_ff[NLOG+1]),
      .cosine  (cosine)
   );

   // delay the cosine to meet the root
   logic signed [XW-1:0] cos_ff [0:ALIGN-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff[0] <= cosine;
         for (int a = 1; a < ALIGN; a++) cos_ff[a] <= cos_ff[a-1];
      end
   end

   localparam int unsigned PW = bmg_pkg::ROOT_W + 1 + XW;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;

   always_comb begin
      prod_in = PW'($signed({1'b0, root})) * PW'(cos_ff[ALIGN-1]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_gaussian_sample = prod_ff[W+29:30];

   a_stall_holds_valids : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff[0]) && $stable(valid_ff[NLOG]) && $stable(rsp_valid))
      else $error("pipeline valid moved during stall");

   a_valid_shifts : assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff[1] == $past(valid_ff[0]) && rsp_valid == $past(valid_ff[DEPTH-2]))
      else $error("valid bit did not follow its word");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted word not in first stage");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid && !valid_ff[0])
      else $error("valid left set after reset");

endmodule

@@ verif/tb_box_muller_gaussian.sv @@
module tb_box_muller_gaussian;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY  = 59;
   localparam int N_RANDOM = 1500;

   // atan(2^-i) in Q0.32 turns
   localparam logic [31:0] ATAN_TURNS [0:27] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005};

   // -2 ln(u) in Q.52
   function automatic logic [63:0] neg2ln_q52(input logic [31:0] u);
      int lead;
      logic [127:0] m;
      logic [63:0] f;
      logic [63:0] lq;
      logic [127:0] prod;
      lead = 31;
      f = '0;
      while (u[lead] == 1'b0) lead--;
      m = 128'(u) << (31 - lead);
      for (int b = 25; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= (128'd1 << 32)) begin
            f[b] = 1'b1;
            m = m >> 1;
         end
      end
      lq = (64'(32 - lead) << 26) - f;
      prod = 128'(lq) * 128'(bmg_pkg::LN2_Q32);
      return 64'(prod >> 5);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // cos(2 pi a) in Q1.30 by rotation CORDIC on turns
   function automatic longint cos_turns_q30(input logic [31:0] a);
      logic [31:0] t;
      logic [1:0] quad;
      longint z, x, y, nx;
      t = a + 32'h20000000;
      quad = t[31:30];
      z = longint'({2'b00, t[29:0]}) - 64'sh20000000;
      x = longint'(bmg_pkg::CORDIC_GAIN_Q30);
      y = 0;
      for (int i = 0; i < 28; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      case (quad)
         2'd0: return x;
         2'd1: return -y;
         2'd2: return -x;
         default: return y;
      endcase
   endfunction

   function automatic logic [31:0] gaussian_of(input logic [31:0] radius,
                                               input logic [31:0] angle);
      longint root, c, v;
      if (radius == 0) radius = bmg_pkg::ZERO_SUBST;
      root = longint'(int_sqrt(neg2ln_q52(radius)));
      c = cos_turns_q30(angle);
      v = (root * c) >>> 30;
      return v[31:0];
   endfunction

   class sample_board;
      logic [31:0] pending[$];
      int errors;

      function void note_pair(logic [31:0] radius, logic [31:0] angle);
         pending.push_back(gaussian_of(radius, angle));
      endfunction

      function void check_sample(logic [31:0] got);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected sample actual %h", $time, got);
            errors++;
         end else begin
            want = pending.pop_front();
            if (want !== got) begin
               $display("%0t: gaussian_sample expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [31:0] req_uniform_radius, req_uniform_angle;
   logic signed [31:0] rsp_gaussian_sample;
   bit calm;
   sample_board board;

   box_muller_gaussian u_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_pair(req_uniform_radius, req_uniform_angle);
      if (!reset && rsp_valid && rsp_ready) board.check_sample(rsp_gaussian_sample);
   end

   // receiver stalls
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready <= calm || ($urandom_range(99) >= 26);
      end
   end

   task automatic send_pair(input logic [31:0] radius, input logic [31:0] angle);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_uniform_radius <= radius;
      req_uniform_angle <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_radius();
      // mix small radii so every leading-one position is hit
      case ($urandom_range(3))
         0: return $urandom() >> $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals [0:7];
      board = new();
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_uniform_radius = 0;
      req_uniform_angle = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // zero radius, extremes, quadrant boundaries
      edge_vals = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h20000000,
                    32'h40000000, 32'hC0000000, 32'h1FFFFFFF};
      for (int i = 0; i < 8; i++) send_pair(edge_vals[i], edge_vals[(i + 3) % 8]);
      send_pair(32'h0, 32'h0);
      send_pair(32'd4295, 32'h60000000);
      send_pair(32'h00000001, 32'h80000000);
      send_pair(32'hFFFFFFFF, 32'h0);
      send_pair(32'h55555555, 32'hAAAAAAAA);
      send_pair(32'hAAAAAAAA, 32'h55555555);
      drain();

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 600 && n < 800);
         send_pair(rand_radius(), $urandom());
      end
      calm = 0;
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
